>>> hdl/lcm_by_euclid_gcd_assert.svh
// Assertion macros for the least common multiple block and its checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LCM_BY_EUCLID_GCD_ASSERT_SVH
`define LCM_BY_EUCLID_GCD_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LCM_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LCM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lcm_pkg.sv
// Shared types and constants for the least common multiple block.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package lcm_pkg;

    localparam int MULTIPLE_BITS = 62;
    localparam int M_DATA_BITS   = ((MULTIPLE_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_EUCLID_DIV,
        ST_QUOT_DIV,
        ST_MUL,
        ST_WRITE
    } lcm_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;           // capture operands of an accepted item
        logic div_start;      // launch the shared divider
        logic div_sel_quot;   // 1: divide second operand by gcd, 0: Euclid step
        logic euclid_update;  // x <= y, y <= remainder
        logic quot_capture;   // keep quotient of second operand by gcd
        logic mul;            // form first operand times quotient
        logic result_load;    // move result into the output register
    } lcm_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic op_zero;
        logic y_zero;
        logic div_done;
    } lcm_status_t;

endpackage

`default_nettype wire

>>> hdl/lcm_div.sv
// Restoring bit-serial divider: one quotient bit per cycle.
// Used by lcm_datapath; no package dependency.
`default_nettype none

module lcm_div #(
    parameter int OPERAND_BITS = 31
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [OPERAND_BITS-1:0] dividend,
    input  logic [OPERAND_BITS-1:0] divisor,
    output logic                    done,
    output logic [OPERAND_BITS-1:0] quotient,
    output logic [OPERAND_BITS-1:0] remainder
);

    localparam int W        = OPERAND_BITS;
    localparam int CNT_BITS = $clog2(W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [W-1:0]        rem_reg, rem_next;
    logic [W-1:0]        quo_reg, quo_next;
    logic [W-1:0]        den_reg, den_next;

    logic [W:0]          shifted;
    logic [W:0]          diff;
    logic                fits;

    always_comb begin
        shifted = {rem_reg, quo_reg[W-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = shifted >= {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(W);
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[W-1:0] : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> hdl/lcm_datapath.sv
// Datapath: operand registers, Euclid registers, shared divider, multiplier
// and the output register. Depends on lcm_pkg and lcm_div.
`default_nettype none

module lcm_datapath #(
    parameter int OPERAND_BITS = 31
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lcm_pkg::lcm_cmd_t                   cmd,
    output lcm_pkg::lcm_status_t                status,
    input  logic [OPERAND_BITS-1:0]             first_operand,
    input  logic [OPERAND_BITS-1:0]             second_operand,
    output logic [lcm_pkg::MULTIPLE_BITS-1:0]   multiple
);

    import lcm_pkg::*;

    localparam int W = OPERAND_BITS;

    logic [W-1:0]             a_reg, b_reg, x_reg, y_reg, q_reg;
    logic [2*W-1:0]           prod_reg;
    logic [MULTIPLE_BITS-1:0] result_reg;

    logic [W-1:0]             div_dividend, div_divisor;
    logic [W-1:0]             div_quotient, div_remainder;
    logic                     div_done;
    logic [2*W-1:0]           prod_next;

    // Euclid steps divide x by y; the last division takes second operand by gcd.
    assign div_dividend = cmd.div_sel_quot ? b_reg : x_reg;
    assign div_divisor  = cmd.div_sel_quot ? x_reg : y_reg;

    lcm_div #(
        .OPERAND_BITS(W)
    ) u_lcm_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign prod_next = {{W{1'b0}}, a_reg} * {{W{1'b0}}, q_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg <= first_operand;
            b_reg <= second_operand;
            x_reg <= first_operand;
            y_reg <= second_operand;
        end else if (cmd.euclid_update) begin
            x_reg <= y_reg;
            y_reg <= div_remainder;
        end
        if (cmd.quot_capture) begin
            q_reg <= div_quotient;
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
        end
        if (cmd.result_load) begin
            result_reg <= status.op_zero ? '0 : MULTIPLE_BITS'(prod_reg);
        end
    end

    always_comb begin
        status.op_zero  = (a_reg == '0) || (b_reg == '0);
        status.y_zero   = (y_reg == '0);
        status.div_done = div_done;
    end

    assign multiple = result_reg;

endmodule

`default_nettype wire

>>> hdl/lcm_ctrl.sv
// Controller state machine: sequences Euclid steps, the quotient division,
// the multiply and the output handshake. Depends on lcm_pkg.
`default_nettype none

module lcm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  lcm_pkg::lcm_status_t status,
    output lcm_pkg::lcm_cmd_t    cmd
);

    import lcm_pkg::*;

    lcm_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) state_next = ST_TEST;
            end
            ST_TEST: begin
                if (status.op_zero) state_next = ST_WRITE;
                else if (status.y_zero) state_next = ST_QUOT_DIV;
                else state_next = ST_EUCLID_DIV;
            end
            ST_EUCLID_DIV: begin
                if (status.div_done) state_next = ST_TEST;
            end
            ST_QUOT_DIV: begin
                if (status.div_done) state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (!out_valid_reg || m_axis_tready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                cmd.load      = s_axis_tvalid;
            end
            ST_TEST: begin
                // y reaching zero leaves the gcd in x
                cmd.div_start    = !status.op_zero;
                cmd.div_sel_quot = status.y_zero;
            end
            ST_EUCLID_DIV: begin
                cmd.euclid_update = status.div_done;
            end
            ST_QUOT_DIV: begin
                cmd.quot_capture = status.div_done;
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
            end
            ST_WRITE: begin
                // hold until the output register is free
                cmd.result_load = !out_valid_reg || m_axis_tready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.result_load) out_valid_next = 1'b1;
        else if (m_axis_tready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;

endmodule

`default_nettype wire

>>> hdl/lcm_by_euclid_gcd.sv
// Least common multiple of two unsigned operands.
// Input item: first_operand and second_operand in s_axis_tdata; result item:
// multiple in m_axis_tdata. Both channels use tvalid/tready handshakes.
// One item is worked on at a time. The gcd comes from Euclid's repeated
// remainder on a shared bit-serial divider (one quotient bit per cycle), then
// the second operand is divided by the gcd and multiplied by the first.
// The number of Euclid remainder steps runs from 1 up to about 45 at 31 bits;
// a zero operand skips the divider. s_axis_tready is high only while waiting
// for an item. The next item can be accepted in the cycle m_axis_tvalid rises.
// The output register holds a finished result while m_axis_tready is low, and
// the next item may be accepted and worked on meanwhile; it then waits.
// Reset (aresetn low, synchronous) drops all valid flags and returns to idle;
// nothing is kept between items.
// Depends on lcm_pkg, lcm_ctrl, lcm_datapath and lcm_div.
`default_nettype none

module lcm_by_euclid_gcd #(
    parameter int OPERAND_BITS = 31
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // first_operand, second_operand, zero fill
    input  logic [((2*OPERAND_BITS+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // multiple, zero fill
    output logic [lcm_pkg::M_DATA_BITS-1:0]       m_axis_tdata
);

    import lcm_pkg::*;

    lcm_cmd_t                 cmd;
    lcm_status_t              status;
    logic [MULTIPLE_BITS-1:0] multiple;

    lcm_ctrl u_lcm_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    lcm_datapath #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_lcm_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .first_operand  (s_axis_tdata[OPERAND_BITS-1:0]),
        .second_operand (s_axis_tdata[2*OPERAND_BITS-1:OPERAND_BITS]),
        .multiple       (multiple)
    );

    assign m_axis_tdata = M_DATA_BITS'(multiple);

endmodule

`default_nettype wire

>>> hdl/lcm_checker.sv
// Port-level checker for the least common multiple block, bound to the top.
// Depends on lcm_pkg and lcm_by_euclid_gcd_assert.svh.
`default_nettype none

`include "lcm_by_euclid_gcd_assert.svh"

module lcm_checker #(
    parameter int OPERAND_BITS = 31
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [((2*OPERAND_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [lcm_pkg::M_DATA_BITS-1:0]     m_axis_tdata
);

    logic       s_fire, m_fire;
    logic [1:0] pending_reg, pending_next;
    logic [((2*OPERAND_BITS+7)/8)*8-1:0] s_data_seen;

    assign s_fire      = s_axis_tvalid && s_axis_tready;
    assign m_fire      = m_axis_tvalid && m_axis_tready;
    assign s_data_seen = s_axis_tdata;

    // count items accepted but not yet delivered
    always_comb begin
        pending_next = pending_reg;
        if (s_fire && !m_fire) pending_next = pending_reg + 2'd1;
        else if (m_fire && !s_fire) pending_next = pending_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    `LCM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result item changed while stalled")

    `LCM_ASSERT_IMPLIES(a_no_invented, aclk, aresetn, m_axis_tvalid,
        pending_reg != 2'd0, "result item without an accepted input item")

    `LCM_ASSERT_IMPLIES(a_pending_bound, aclk, aresetn, 1'b1,
        pending_reg != 2'd3, "more than two items in flight")

    `LCM_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_fire && (s_data_seen == s_axis_tdata),
        !s_axis_tready, "input ready right after accepting an item")

endmodule

bind lcm_by_euclid_gcd lcm_checker #(
    .OPERAND_BITS(OPERAND_BITS)
) u_lcm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for lcm_by_euclid_gcd: directed table, then random operand pairs.
// Depends on lcm_pkg and hdl; expected multiples come from the table or a local Euclid predictor.
`default_nettype none

module tb;
    import lcm_pkg::*;

    localparam int          OPERAND_BITS = 31;
    localparam int          S_DATA_BITS  = ((2 * OPERAND_BITS + 7) / 8) * 8;
    localparam bit [30:0]   OPERAND_MAX  = 31'h7FFF_FFFF;
    localparam int          RANDOM_ITEMS = 530;
    localparam int          IDLE_LIMIT   = 12000;
    localparam int          DRAIN_CYCLES = 1600;
    localparam int          REPORT_MAX   = 10;

    typedef struct packed {
        bit [30:0] first;
        bit [30:0] second;
        bit        typed;       // multiple below is given, not predicted
        bit [61:0] multiple;
    } lcm_vector_t;

    typedef struct {
        bit [30:0] first;
        bit [30:0] second;
        bit [61:0] multiple;
    } lcm_expect_t;

    localparam int DIRECTED_COUNT = 18;
    lcm_vector_t directed_vectors [DIRECTED_COUNT] = '{
        '{31'd0,          31'd0,          1'b1, 62'd0},
        '{31'd0,          OPERAND_MAX,    1'b1, 62'd0},
        '{OPERAND_MAX,    31'd0,          1'b1, 62'd0},
        '{31'd1,          31'd1,          1'b1, 62'd1},
        '{OPERAND_MAX,    OPERAND_MAX,    1'b1, 62'd2147483647},
        '{OPERAND_MAX,    31'd1,          1'b1, 62'd2147483647},
        '{31'd1,          OPERAND_MAX,    1'b1, 62'd2147483647},
        '{31'd6,          31'd3,          1'b1, 62'd6},
        '{31'd3,          31'd6,          1'b1, 62'd6},
        '{31'd12,         31'd18,         1'b1, 62'd36},
        '{31'd7,          31'd5,          1'b1, 62'd35},
        '{31'h4000_0000,  31'h0000_0400,  1'b1, 62'h4000_0000},
        '{OPERAND_MAX,    31'h7FFF_FFFE,  1'b0, 62'd0},
        '{31'd1836311903, 31'd1134903170, 1'b0, 62'd0},   // longest Euclid chain
        '{31'h5555_5555,  31'h2AAA_AAAA,  1'b0, 62'd0},
        '{31'h4000_0000,  31'h3FFF_FFFF,  1'b0, 62'd0},
        '{31'd2147483629, 31'd2147483587, 1'b0, 62'd0},
        '{31'd46341,      31'd46340,      1'b0, 62'd0}
    };

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // first_operand, second_operand, zero fill
    logic [S_DATA_BITS-1:0]  s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // multiple, zero fill
    logic [M_DATA_BITS-1:0]  m_axis_tdata;

    lcm_expect_t pending_multiples [$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    bit          calm = 1'b0;

    lcm_by_euclid_gcd #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic bit [61:0] lcm_of(bit [30:0] first, bit [30:0] second);
        bit [63:0] x;
        bit [63:0] y;
        bit [63:0] r;
        bit [63:0] g;
        x = 64'(first);
        y = 64'(second);
        if (x == 0 || y == 0) return '0;
        if (x % y == 0) return x[61:0];
        if (y % x == 0) return y[61:0];
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        g = x;
        r = g * (64'(first) / g) * (64'(second) / g);
        return r[61:0];
    endfunction

    // Mostly short gaps, a few long ones, none during a calm stretch.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    task automatic pick_operands(output bit [30:0] first, output bit [30:0] second);
        int        kind;
        int        n;
        bit [31:0] g;
        bit [31:0] f0;
        bit [31:0] f1;
        bit [31:0] t;
        bit [63:0] p;
        kind = $urandom_range(0, 15);
        case (kind)
            0, 1, 2: begin
                first  = 31'($urandom());
                second = 31'($urandom());
            end
            3, 4, 5: begin
                // shared factor, so the gcd is above one
                g = $urandom_range(2, 65535);
                p = 64'(g) * $urandom_range(1, 32'(OPERAND_MAX) / g);
                first = p[30:0];
                p = 64'(g) * $urandom_range(1, 32'(OPERAND_MAX) / g);
                second = p[30:0];
            end
            6, 7: begin
                // one operand divides the other
                g = $urandom_range(1, 65536);
                p = 64'(g) * $urandom_range(1, 32'(OPERAND_MAX) / g);
                if ($urandom_range(0, 1)) begin
                    first = p[30:0];
                    second = g[30:0];
                end else begin
                    first = g[30:0];
                    second = p[30:0];
                end
            end
            8, 9: begin
                first  = 31'($urandom_range(0, 300));
                second = 31'($urandom_range(0, 300));
            end
            10: begin
                first  = 31'($urandom());
                second = '0;
                if ($urandom_range(0, 1)) begin
                    second = first;
                    first  = '0;
                end
            end
            11: begin
                first  = 31'($urandom());
                second = first;
            end
            12: begin
                // consecutive Fibonacci numbers walk Euclid the longest
                n = $urandom_range(1, 44);
                f0 = 1;
                f1 = 1;
                repeat (n) begin
                    t  = f0 + f1;
                    f0 = f1;
                    f1 = t;
                end
                first  = f1[30:0];
                second = f0[30:0];
            end
            default: begin
                first  = OPERAND_MAX - 31'($urandom_range(0, 1000));
                second = OPERAND_MAX - 31'($urandom_range(0, 1000));
            end
        endcase
    endtask

    // Present one item and hold it until accepted; valid stays high for a zero gap.
    task automatic send_operands(bit [30:0] first, bit [30:0] second, bit typed,
                                 bit [61:0] given);
        int          gap;
        lcm_expect_t entry;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, second, first};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        entry.first    = first;
        entry.second   = second;
        entry.multiple = typed ? given : lcm_of(first, second);
        pending_multiples.push_back(entry);
    endtask

    task automatic note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) $display("%s", what);
    endtask

    // Result side: random stalls, then compare each accepted item with the oldest expectation.
    always @(posedge aclk) begin
        lcm_expect_t entry;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_multiples.size() == 0) begin
                    note_mismatch($sformatf("unexpected result multiple=%0d",
                                            m_axis_tdata[MULTIPLE_BITS-1:0]));
                end else begin
                    entry = pending_multiples.pop_front();
                    if (m_axis_tdata[MULTIPLE_BITS-1:0] !== entry.multiple)
                        note_mismatch($sformatf(
                            "lcm(%0d, %0d): expected %0d, got %0d",
                            entry.first, entry.second, entry.multiple,
                            m_axis_tdata[MULTIPLE_BITS-1:0]));
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                stall_left <= pick_gap();
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no item moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("lcm_by_euclid_gcd: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        bit [30:0] first;
        bit [30:0] second;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            send_operands(directed_vectors[i].first, directed_vectors[i].second,
                          directed_vectors[i].typed, directed_vectors[i].multiple);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // switch idling on or off for stretches of items
            if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            pick_operands(first, second);
            send_operands(first, second, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        while (pending_multiples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_multiples.size() == 0) begin
            $display("lcm_by_euclid_gcd: match");
        end else begin
            $display("lcm_by_euclid_gcd: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
